@@ src/tfd_pkg.sv @@
package tfd_pkg;

  // Size limits of the image counters.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // Configuration port.
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int FMT_W     = 4;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(32);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(32);

  // Depth of the queue between the front and the back part.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FORMAT = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } cfg_idx_e;

  typedef enum logic [FMT_W-1:0] {
    FMT_RGBA32 = 4'd0,
    FMT_RGB5A1 = 4'd1,
    FMT_I4     = 4'd2,
    FMT_I8     = 4'd3,
    FMT_IA4    = 4'd4,
    FMT_IA8    = 4'd5,
    FMT_IA16   = 4'd6,
    FMT_CI4    = 4'd7,
    FMT_CI8    = 4'd8
  } fmt_e;

  typedef struct packed {
    logic [FMT_W-1:0] fmt;
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
    logic             clear;
  } cfg_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } rgba_t;

  // One decoded input byte: one or two pixels ready to be sent.
  typedef struct packed {
    rgba_t px0;
    rgba_t px1;
    logic  two;
  } job_t;

endpackage

@@ src/tfd_if.sv @@
interface byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       row_end;
  logic       image_end;
  logic       run_last;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output row_end, output image_end, output run_last, input ready);
  modport sink (input valid, input red, input green, input blue, input alpha,
                input row_end, input image_end, input run_last, output ready);
endinterface

@@ src/tfd_front.sv @@
module tfd_front
  import tfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  output logic       in_ready_o,
  input  logic       q_full_i,
  output logic       push_o,
  output job_t       job_o
);

  logic [1:0]  held_q, held_d;
  logic [23:0] partial_q, partial_d;
  logic        accept;
  logic [2:0]  need;
  logic        gathers;
  logic        complete;
  logic [31:0] word;
  logic [3:0]  hi;
  logic [3:0]  lo;
  logic        emits;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign hi         = in_byte_i[7:4];
  assign lo         = in_byte_i[3:0];
  assign word       = {partial_q, in_byte_i};
  assign complete   = (3'({1'b0, held_q}) + 3'd1) >= need;

  // Classify the byte and expand the pixels it yields.
  always_comb begin
    need    = 3'd1;
    gathers = 1'b0;
    emits   = 1'b0;
    job_o   = '0;
    case (fmt_e'(cfg_i.fmt))
      FMT_RGBA32: begin
        need    = 3'd4;
        gathers = 1'b1;
        emits   = complete;
        job_o.px0 = '{r: word[31:24], g: word[23:16], b: word[15:8], a: word[7:0]};
      end
      FMT_RGB5A1: begin
        need    = 3'd2;
        gathers = 1'b1;
        emits   = complete;
        job_o.px0 = '{r: {word[15:11], 3'b000}, g: {word[10:6], 3'b000},
                      b: {word[5:1], 3'b000}, a: {8{word[0]}}};
      end
      FMT_I4, FMT_CI4: begin
        emits     = 1'b1;
        job_o.two = 1'b1;
        job_o.px0 = '{r: {hi, 4'h0}, g: {hi, 4'h0}, b: {hi, 4'h0}, a: 8'hFF};
        job_o.px1 = '{r: {lo, 4'h0}, g: {lo, 4'h0}, b: {lo, 4'h0}, a: 8'hFF};
      end
      FMT_I8, FMT_CI8: begin
        emits     = 1'b1;
        job_o.px0 = '{r: in_byte_i, g: in_byte_i, b: in_byte_i, a: 8'hFF};
      end
      FMT_IA4: begin
        emits     = 1'b1;
        job_o.two = 1'b1;
        job_o.px0 = '{r: {hi[3:1], 5'b0}, g: {hi[3:1], 5'b0}, b: {hi[3:1], 5'b0},
                      a: {8{hi[0]}}};
        job_o.px1 = '{r: {lo[3:1], 5'b0}, g: {lo[3:1], 5'b0}, b: {lo[3:1], 5'b0},
                      a: {8{lo[0]}}};
      end
      FMT_IA8: begin
        emits     = 1'b1;
        job_o.px0 = '{r: {hi, 4'h0}, g: {hi, 4'h0}, b: {hi, 4'h0}, a: {lo, 4'h0}};
      end
      FMT_IA16: begin
        need    = 3'd2;
        gathers = 1'b1;
        emits   = complete;
        job_o.px0 = '{r: word[15:8], g: word[15:8], b: word[15:8], a: word[7:0]};
      end
      default: begin
        emits = 1'b0;
      end
    endcase
  end

  assign push_o = accept && emits;

  // Word assembly for the multi-byte formats.
  always_comb begin
    held_d    = held_q;
    partial_d = partial_q;
    if (cfg_i.clear) begin
      held_d    = '0;
      partial_d = '0;
    end else if (accept && gathers) begin
      if (complete) begin
        held_d    = '0;
        partial_d = '0;
      end else begin
        held_d    = held_q + 2'd1;
        partial_d = {partial_q[15:0], in_byte_i};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q    <= '0;
      partial_q <= '0;
    end else begin
      held_q    <= held_d;
      partial_q <= partial_d;
    end
  end

endmodule

@@ src/tfd_queue.sv @@
module tfd_queue
  import tfd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output job_t head_o
);

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push;
  logic              do_pop;

  assign full_o  = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (32'(wr_q) == QUEUE_DEPTH - 1) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (32'(rd_q) == QUEUE_DEPTH - 1) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ src/tfd_back.sv @@
module tfd_back
  import tfd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic job_valid_i,
  input  job_t job_i,
  output logic pop_o,
  pixel_if.source pix_o
);

  logic             out_valid_q;
  rgba_t            px_q;
  logic             row_end_q, image_end_q, run_last_q;
  logic             phase_q;
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] w_last;
  logic [ROW_W-1:0] h_last;
  logic             load;
  logic             emit;
  logic             last_of_job;
  logic             rend;
  logic             iend;

  // Last column and row index after clamping the dimensions.
  always_comb begin
    if (cfg_i.width == '0) begin
      w_last = '0;
    end else if (32'(cfg_i.width) > MAX_WIDTH) begin
      w_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      w_last = COL_W'(cfg_i.width - 1'b1);
    end
    if (cfg_i.height == '0) begin
      h_last = '0;
    end else if (32'(cfg_i.height) > MAX_HEIGHT) begin
      h_last = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      h_last = ROW_W'(cfg_i.height - 1'b1);
    end
  end

  assign load        = !out_valid_q || pix_o.ready;
  assign emit        = load && job_valid_i;
  assign last_of_job = !job_i.two || phase_q;
  assign pop_o       = emit && last_of_job;
  assign rend        = col_q >= w_last;
  assign iend        = rend && (row_q >= h_last);

  // Position counters and pixel phase within the current job.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      phase_q <= 1'b0;
    end else if (cfg_i.clear) begin
      col_q   <= '0;
      row_q   <= '0;
      phase_q <= 1'b0;
    end else if (emit) begin
      phase_q <= !last_of_job;
      if (rend) begin
        col_q <= '0;
        row_q <= iend ? '0 : row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      px_q        <= phase_q ? job_i.px1 : job_i.px0;
      row_end_q   <= rend;
      image_end_q <= iend;
      run_last_q  <= last_of_job;
    end
  end

  assign pix_o.valid     = out_valid_q;
  assign pix_o.red       = px_q.r;
  assign pix_o.green     = px_q.g;
  assign pix_o.blue      = px_q.b;
  assign pix_o.alpha     = px_q.a;
  assign pix_o.row_end   = row_end_q;
  assign pix_o.image_end = image_end_q;
  assign pix_o.run_last  = run_last_q;

  // The last pixel of an image always closes a row.
  a_image_end_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && image_end_q |-> row_end_q)
    else $error("image end without row end");

  // The second pixel phase only exists while its job is still queued.
  a_phase_job : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> job_valid_i)
    else $error("second pixel phase with empty queue");

  // The first pixel of a two-pixel job never carries the run marker.
  a_run_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && job_i.two && !phase_q |=> !run_last_q)
    else $error("run marker on first pixel of a pair");

endmodule

@@ src/texel_format_decoder.sv @@
// Texel format decoder: expands raw big-endian texture bytes into RGBA pixels.
// Input channel byte_in carries one texture byte per item, in memory order.
// Output channel pixel_out carries one pixel per item, with row and image end
// flags and a run_last flag on the last pixel produced by each byte.
// The configuration port (cfg_we_i, cfg_idx_i, cfg_data_i) selects the format
// and image size; writes to known indices restart word assembly and the image.
// The byte that completes a pixel enters the queue at its accepting edge;
// the output register then loads the pixel from the queue head, and the
// second pixel of a 4-bit byte follows the first from the same entry.
// The output register sends one pixel per cycle while the receiver is ready,
// so 4-bit formats give two pixels per byte, others up to one byte per cycle.
// A two-entry queue between the byte decoder and the pixel sender lets the
// input keep flowing while the output register waits.
// When the receiver stalls, the held pixel stays on pixel_out, the queue fills
// and byte_in.ready drops once both entries are taken.
// Reset sets format rgba32, a 32 by 32 image, and empties every stage.
module texel_format_decoder
  import tfd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  byte_if.sink                 byte_in,
  pixel_if.source              pixel_out,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  logic [FMT_W-1:0] fmt_q;
  logic [CFG_W-1:0] width_q, height_q;
  logic             clear;
  cfg_t             cfg;
  logic             q_full;
  logic             push;
  job_t             push_job;
  logic             pop;
  logic             q_valid;
  job_t             head_job;

  // Register decode; any known index also restarts the image.
  always_comb begin
    case (cfg_idx_e'(cfg_idx_i))
      REG_FORMAT, REG_WIDTH, REG_HEIGHT: clear = cfg_we_i;
      default:                           clear = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= FMT_RGBA32;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_FORMAT: fmt_q    <= cfg_data_i[FMT_W-1:0];
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        default:    fmt_q    <= fmt_q;
      endcase
    end
  end

  assign cfg = '{fmt: fmt_q, width: width_q, height: height_q, clear: clear};

  tfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (byte_in.valid),
    .in_byte_i  (byte_in.data_byte),
    .in_ready_o (byte_in.ready),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  tfd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .head_o     (head_job)
  );

  tfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .job_valid_i (q_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .pix_o       (pixel_out)
  );

endmodule

@@ dv/texel_format_decoder_tb.sv @@
`timescale 1ns / 1ps

module texel_format_decoder_tb;
  import tfd_pkg::*;

  localparam int ITEM_TARGET   = 850;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 20;
  localparam int STALL_LIMIT   = 2000;

  // Index with no register behind it; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic       row_end;
    logic       image_end;
    logic       run_last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Signals driven by the testbench, each from one process.
  logic                 send_valid = 1'b0;
  logic [7:0]           send_data = 8'h00;
  logic                 take_ready = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = REG_FORMAT;
  logic [CFG_W-1:0]     cfg_data = '0;

  byte_if  byte_ch ();
  pixel_if pixel_ch ();

  assign byte_ch.valid     = send_valid;
  assign byte_ch.data_byte = send_data;
  assign pixel_ch.ready    = take_ready;

  texel_format_decoder dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .byte_in    (byte_ch),
    .pixel_out  (pixel_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [7:0] byte_queue[$];
  pixel_t     pending_pixels[$];
  int         errors = 0;
  bit         byte_taken = 1'b0;
  int         gap_pct = 0;
  int         stall_pct = 0;
  bit         hold_request = 1'b0;
  int         idle_cycles = 0;

  // Predicted decoder state and register copies.
  logic [FMT_W-1:0] fmt_reg = FMT_RGBA32;
  logic [CFG_W-1:0] width_reg = WIDTH_RST;
  logic [CFG_W-1:0] height_reg = HEIGHT_RST;
  logic [1:0]       held_bytes = '0;
  logic [23:0]      partial_word = '0;
  int unsigned      col_pos = 0;
  int unsigned      row_pos = 0;

  function automatic int unsigned effective_dim(input logic [CFG_W-1:0] v, input int limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  function automatic void set_register(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_W-1:0] val);
    case (idx)
      REG_FORMAT: fmt_reg = val[FMT_W-1:0];
      REG_WIDTH:  width_reg = val;
      REG_HEIGHT: height_reg = val;
      default:    return;
    endcase
    // Any real register write restarts word assembly and the image.
    held_bytes = '0;
    partial_word = '0;
    col_pos = 0;
    row_pos = 0;
  endfunction

  // Collects bytes of an n-byte big-endian word; returns 1 when it is complete.
  function automatic bit gather_word(input logic [7:0] b, input int n,
                                     output logic [31:0] word);
    word = '0;
    if (int'(held_bytes) + 1 >= n) begin
      word = {partial_word, b};
      held_bytes = '0;
      partial_word = '0;
      return 1'b1;
    end
    partial_word = {partial_word[15:0], b};
    held_bytes = held_bytes + 2'd1;
    return 1'b0;
  endfunction

  // Queues one expected pixel and advances the column and row position.
  function automatic void emit_pixel(input logic [7:0] r, input logic [7:0] g,
                                     input logic [7:0] b, input logic [7:0] a);
    int unsigned w_eff;
    int unsigned h_eff;
    pixel_t px;
    w_eff = effective_dim(width_reg, MAX_WIDTH);
    h_eff = effective_dim(height_reg, MAX_HEIGHT);
    px.r = r;
    px.g = g;
    px.b = b;
    px.a = a;
    px.row_end = (col_pos + 1 >= w_eff);
    px.image_end = px.row_end && (row_pos + 1 >= h_eff);
    px.run_last = 1'b0;
    pending_pixels.push_back(px);
    if (px.row_end) begin
      col_pos = 0;
      row_pos = px.image_end ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  // Works out the pixels that one accepted byte produces.
  function automatic void decode_byte(input logic [7:0] b);
    logic [31:0] word;
    logic [3:0]  hi;
    logic [3:0]  lo;
    int          before_cnt;
    pixel_t      px;
    hi = b[7:4];
    lo = b[3:0];
    before_cnt = pending_pixels.size();
    case (fmt_reg)
      FMT_RGBA32: begin
        if (gather_word(b, 4, word))
          emit_pixel(word[31:24], word[23:16], word[15:8], word[7:0]);
      end
      FMT_RGB5A1: begin
        if (gather_word(b, 2, word))
          emit_pixel({word[15:11], 3'b000}, {word[10:6], 3'b000},
                     {word[5:1], 3'b000}, {8{word[0]}});
      end
      FMT_I4, FMT_CI4: begin
        emit_pixel({hi, 4'h0}, {hi, 4'h0}, {hi, 4'h0}, 8'hFF);
        emit_pixel({lo, 4'h0}, {lo, 4'h0}, {lo, 4'h0}, 8'hFF);
      end
      FMT_I8, FMT_CI8: begin
        emit_pixel(b, b, b, 8'hFF);
      end
      FMT_IA4: begin
        emit_pixel({hi[3:1], 5'b0}, {hi[3:1], 5'b0}, {hi[3:1], 5'b0}, {8{hi[0]}});
        emit_pixel({lo[3:1], 5'b0}, {lo[3:1], 5'b0}, {lo[3:1], 5'b0}, {8{lo[0]}});
      end
      FMT_IA8: begin
        emit_pixel({hi, 4'h0}, {hi, 4'h0}, {hi, 4'h0}, {lo, 4'h0});
      end
      FMT_IA16: begin
        if (gather_word(b, 2, word))
          emit_pixel(word[15:8], word[15:8], word[15:8], word[7:0]);
      end
      default: begin
        // Unknown formats swallow the byte.
      end
    endcase
    // Flag the last pixel that this byte produced.
    if (pending_pixels.size() > before_cnt) begin
      px = pending_pixels.pop_back();
      px.run_last = 1'b1;
      pending_pixels.push_back(px);
    end
  endfunction

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Byte driver: holds each item until it is taken, with random gaps between items.
  int send_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (!send_valid || byte_taken) begin
        byte_taken = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
          send_valid <= 1'b0;
        end else if (byte_queue.size() > 0) begin
          send_data <= byte_queue.pop_front();
          send_valid <= 1'b1;
          if ($urandom_range(0, 99) < gap_pct) send_gap = $urandom_range(1, 10);
        end else begin
          send_valid <= 1'b0;
        end
      end
    end
  end

  // Pixel receiver: random stall bursts, plus one long hold on request.
  int stall_left = 0;
  int hold_left = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
        take_ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD - 1;
        take_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        take_ready <= 1'b0;
      end else begin
        take_ready <= 1'b1;
        if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 10);
      end
    end
  end

  // Monitor: predicts on every accepted byte and checks every accepted pixel.
  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (rst_n) begin
      if (byte_ch.valid && byte_ch.ready) begin
        decode_byte(byte_ch.data_byte);
        byte_taken = 1'b1;
      end
      if (pixel_ch.valid && pixel_ch.ready) begin
        got.r = pixel_ch.red;
        got.g = pixel_ch.green;
        got.b = pixel_ch.blue;
        got.a = pixel_ch.alpha;
        got.row_end = pixel_ch.row_end;
        got.image_end = pixel_ch.image_end;
        got.run_last = pixel_ch.run_last;
        if (pending_pixels.size() == 0) begin
          $display("%0t: pixel mismatch, expected none, got %p", $time, got);
          errors++;
        end else begin
          want = pending_pixels.pop_front();
          compare_field("red", want.r, got.r);
          compare_field("green", want.g, got.g);
          compare_field("blue", want.b, got.b);
          compare_field("alpha", want.a, got.a);
          compare_field("row_end", want.row_end, got.row_end);
          compare_field("image_end", want.image_end, got.image_end);
          compare_field("run_last", want.run_last, got.run_last);
        end
      end
    end
  end

  // Watchdog on stretches with no item moving and no register write.
  always @(posedge clk) begin
    if ((byte_ch.valid && byte_ch.ready) || (pixel_ch.valid && pixel_ch.ready) || cfg_we)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, idle_cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Waits until every byte is taken and every predicted pixel has arrived.
  task automatic wait_drained();
    while (byte_queue.size() != 0 || send_valid || pending_pixels.size() != 0)
      @(posedge clk);
  endtask

  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    set_register(idx, val);
  endtask

  task automatic start_image(input logic [FMT_W-1:0] fmt, input logic [CFG_W-1:0] wd,
                             input logic [CFG_W-1:0] ht);
    settle();
    write_reg(REG_FORMAT, CFG_W'(fmt));
    write_reg(REG_WIDTH, wd);
    write_reg(REG_HEIGHT, ht);
  endtask

  // Image sizes: mostly small, sometimes zero, the limit or beyond it.
  function automatic logic [CFG_W-1:0] pick_dim(input int limit);
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return CFG_W'(1);
      2:       return CFG_W'(limit);
      3:       return CFG_W'($urandom_range(limit + 1, (1 << CFG_W) - 1));
      4:       return '1;
      default: return CFG_W'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 10;
      default: return 35;
    endcase
  endfunction

  initial begin
    int               fed;
    int               n;
    int               phase;
    bit               pause;
    logic [FMT_W-1:0] fmt;
    fed = 0;
    phase = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: one full rgba32 word, then a partial word that must
    // survive a write to the spare index.
    byte_queue.push_back(8'h00);
    byte_queue.push_back(8'hFF);
    byte_queue.push_back(8'h80);
    byte_queue.push_back(8'h7F);
    byte_queue.push_back(8'h01);
    byte_queue.push_back(8'h02);
    settle();
    write_reg(REG_SPARE, '1);
    byte_queue.push_back(8'h03);
    byte_queue.push_back(8'h04);

    // Every other format on a small odd-width image, then an unknown format.
    for (int f = FMT_RGB5A1; f <= FMT_CI8; f++) begin
      start_image(FMT_W'(f), CFG_W'(3), CFG_W'(2));
      byte_queue.push_back(8'hFF);
      byte_queue.push_back(8'h00);
    end
    start_image(FMT_W'((1 << FMT_W) - 1), CFG_W'(3), CFG_W'(2));
    byte_queue.push_back(8'hAA);
    byte_queue.push_back(8'h55);

    // Long receiver hold while bytes keep coming, so the input backs up.
    gap_pct = 10;
    stall_pct = 10;
    start_image(FMT_I4, CFG_W'(5), CFG_W'(3));
    hold_request = 1'b1;
    for (int i = 0; i < 60; i++) byte_queue.push_back(8'($urandom_range(0, 255)));
    fed += 60;

    // Random images; the last part runs without random gaps or stalls.
    while (fed < ITEM_TARGET) begin
      settle();
      if (fed > ITEM_TARGET * 9 / 10) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        gap_pct = pick_pct();
        stall_pct = pick_pct();
      end
      if ($urandom_range(0, 11) < 9)
        fmt = FMT_W'($urandom_range(0, int'(FMT_CI8)));
      else
        fmt = FMT_W'($urandom_range(int'(FMT_CI8) + 1, (1 << FMT_W) - 1));
      start_image(fmt, pick_dim(MAX_WIDTH), pick_dim(MAX_HEIGHT));
      n = $urandom_range(8, 60);
      pause = (phase == 0) || ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n; i++) begin
        // Sender pause: hold back until every expected pixel has come.
        if (pause && i == n / 2) wait_drained();
        byte_queue.push_back(8'($urandom_range(0, 255)));
      end
      fed += n;
      phase++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/tfd_pkg.sv
src/tfd_if.sv
src/tfd_front.sv
src/tfd_queue.sv
src/tfd_back.sv
src/texel_format_decoder.sv
dv/texel_format_decoder_tb.sv
